[design/kmp_pkg.sv]
package kmp_pkg;

  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int RESULT_W = 32;

  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_RESTART = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TEXT    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_END     = 3'd4;

  localparam logic RK_MATCH   = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;          // latch the incoming byte
    logic clear;         // empty the pattern
    logic restart;       // clear text position, match state and count
    logic set_ovf;       // append beyond capacity
    logic append_start;  // write pattern byte, seed the failure walk
    logic text_start;    // advance position, seed the match walk
    logic follow;        // k <= failure link
    logic append_done;   // write failure entry, grow pattern
    logic count;         // bump match counter
    logic text_done;     // store new matched length
    logic tail_sel;      // address the last failure entry
    logic tail_fix;      // matched length <= last failure entry
    logic emit;          // load the result register
    logic emit_sum;      // result is a summary
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic size_zero;
    logic size_full;
    logic k_zero;
    logic pat_eq;
    logic full_match;
    logic out_busy;
  } stat_t;

endpackage

[design/kmp_in_if.sv]
interface kmp_in_if;
  logic                         valid;
  logic                         ready;
  logic [kmp_pkg::OPCODE_W-1:0] opcode;
  logic [kmp_pkg::BYTE_W-1:0]   byte_value;

  modport source (output valid, output opcode, output byte_value, input ready);
  modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

[design/kmp_out_if.sv]
interface kmp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [kmp_pkg::RESULT_W-1:0] match_position;
  logic [kmp_pkg::RESULT_W-1:0] match_total;
  logic                         invalid_lengths;
  logic                         pattern_overflow;

  modport source (output valid, output result_kind, output match_position,
                  output match_total, output invalid_lengths,
                  output pattern_overflow, input ready);
  modport sink   (input valid, input result_kind, input match_position,
                  input match_total, input invalid_lengths,
                  input pattern_overflow, output ready);
endinterface

[design/kmp_ctrl.sv]
module kmp_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [kmp_pkg::OPCODE_W-1:0] in_opcode,
  output logic                         in_ready,
  input  kmp_pkg::stat_t               stat,
  output kmp_pkg::cmd_t                cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state, state_next;
  logic       is_text, is_text_next;
  logic       emit_sum, emit_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      is_text  <= 1'b0;
      emit_sum <= 1'b0;
    end else begin
      state    <= state_next;
      is_text  <= is_text_next;
      emit_sum <= emit_sum_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.emit_sum  = emit_sum;
    state_next    = state;
    is_text_next  = is_text;
    emit_sum_next = emit_sum;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_opcode)
            kmp_pkg::OP_CLEAR:   cmd.clear = 1'b1;
            kmp_pkg::OP_RESTART: cmd.restart = 1'b1;
            kmp_pkg::OP_APPEND: begin
              is_text_next = 1'b0;
              if (stat.size_full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                cmd.append_start = 1'b1;
                if (!stat.size_zero) state_next = S_READ;
              end
            end
            kmp_pkg::OP_TEXT: begin
              is_text_next   = 1'b1;
              emit_sum_next  = 1'b0;
              cmd.text_start = 1'b1;
              if (!stat.size_zero) state_next = S_READ;
            end
            kmp_pkg::OP_END: begin
              emit_sum_next = 1'b1;
              state_next    = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (!stat.k_zero && !stat.pat_eq) begin
          cmd.follow = 1'b1;
          state_next = S_READ;
        end else if (!is_text) begin
          cmd.append_done = 1'b1;
          state_next      = S_IDLE;
        end else if (stat.full_match) begin
          cmd.count  = 1'b1;
          state_next = S_TAIL;
        end else begin
          cmd.text_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TAIL: begin
        cmd.tail_sel = 1'b1;
        state_next   = S_FIX;
      end
      S_FIX: begin
        cmd.tail_fix = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result loaded over an untaken result");

  a_follow_link: assert property (@(posedge clk) disable iff (rst)
    cmd.follow |-> !stat.k_zero)
    else $error("failure link followed from length zero");

  a_tail_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_TAIL |=> state == S_FIX ##1 state == S_EMIT)
    else $error("match tail sequence broken");

  a_match_mode: assert property (@(posedge clk) disable iff (rst)
    cmd.count |-> is_text && stat.full_match)
    else $error("match counted outside a text walk");

endmodule

[design/kmp_dp.sv]
module kmp_dp #(
  parameter int MAX_PATTERN    = 64,
  parameter int POSITION_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kmp_pkg::cmd_t              cmd,
  output kmp_pkg::stat_t             stat,
  input  logic [kmp_pkg::BYTE_W-1:0] byte_value,
  kmp_out_if.source                  results
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PW    = POSITION_WIDTH;
  localparam int CW    = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
  localparam int SW    = (PW > kmp_pkg::RESULT_W) ? PW : kmp_pkg::RESULT_W;

  logic [kmp_pkg::BYTE_W-1:0] pat_mem [MAX_PATTERN];
  logic [IDX_W-1:0]           fail_mem [MAX_PATTERN];
  logic [kmp_pkg::BYTE_W-1:0] rd_pat;
  logic [IDX_W-1:0]           rd_fail;

  logic [LEN_W-1:0]            size, bpl, matched, k;
  logic                        ovf;
  logic [PW-1:0]               pos, idx;
  logic [kmp_pkg::RESULT_W-1:0] cnt;
  logic [kmp_pkg::BYTE_W-1:0]  cur_byte;

  logic [LEN_W-1:0] k_new, k_less, size_less;
  logic [IDX_W-1:0] fail_raddr, fail_waddr, fail_wdata;
  logic             fail_we;

  assign k_less    = k - LEN_W'(1);
  assign size_less = size - LEN_W'(1);
  assign k_new     = k + LEN_W'(stat.pat_eq);

  assign fail_raddr = cmd.tail_sel ? size_less[IDX_W-1:0] : k_less[IDX_W-1:0];
  assign fail_we    = (cmd.append_start && stat.size_zero) || cmd.append_done;
  assign fail_waddr = size[IDX_W-1:0];
  assign fail_wdata = cmd.append_done ? k_new[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.append_start) pat_mem[size[IDX_W-1:0]] <= byte_value;
    rd_pat <= pat_mem[k[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
    rd_fail <= fail_mem[fail_raddr];
  end

  assign stat.size_zero  = (size == '0);
  assign stat.size_full  = (size == LEN_W'(MAX_PATTERN));
  assign stat.k_zero     = (k == '0);
  assign stat.pat_eq     = (rd_pat == cur_byte);
  assign stat.full_match = (k_new == size);
  assign stat.out_busy   = results.valid && !results.ready;

  always_ff @(posedge clk) begin
    if (cmd.take) cur_byte <= byte_value;
    if (cmd.append_start) k <= bpl;
    if (cmd.text_start) begin
      idx <= pos;
      k   <= (matched >= size) ? '0 : matched;
    end
    if (cmd.follow) k <= LEN_W'(rd_fail);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size    <= '0;
      bpl     <= '0;
      ovf     <= 1'b0;
      matched <= '0;
      pos     <= '0;
      cnt     <= '0;
    end else begin
      if (cmd.clear) begin
        size    <= '0;
        bpl     <= '0;
        ovf     <= 1'b0;
        matched <= '0;
      end
      if (cmd.restart) begin
        pos     <= '0;
        matched <= '0;
        cnt     <= '0;
      end
      if (cmd.set_ovf) ovf <= 1'b1;
      if (cmd.append_start && stat.size_zero) begin
        bpl  <= '0;
        size <= LEN_W'(1);
      end
      if (cmd.append_done) begin
        bpl  <= k_new;
        size <= size + LEN_W'(1);
      end
      if (cmd.text_start && pos != '1) pos <= pos + PW'(1);
      if (cmd.text_done) matched <= k_new;
      if (cmd.tail_fix) matched <= LEN_W'(rd_fail);
      if (cmd.count && cnt != '1) cnt <= cnt + kmp_pkg::RESULT_W'(1);
    end
  end

  // Start of match from the index of its last byte
  logic [CW-1:0] idx_p1, m_ext, start;
  logic [SW-1:0] start_ext;
  logic          bad;

  assign idx_p1    = CW'(idx) + CW'(1);
  assign m_ext     = CW'(size);
  assign start     = (idx_p1 >= m_ext) ? idx_p1 - m_ext : '0;
  assign start_ext = SW'(start[PW-1:0]);
  assign bad       = stat.size_zero || (m_ext > CW'(pos));

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.result_kind      <= cmd.emit_sum ? kmp_pkg::RK_SUMMARY : kmp_pkg::RK_MATCH;
      results.match_position   <= cmd.emit_sum ? '0 : start_ext[kmp_pkg::RESULT_W-1:0];
      results.match_total      <= (cmd.emit_sum && !bad) ? cnt : '0;
      results.invalid_lengths  <= cmd.emit_sum && bad;
      results.pattern_overflow <= ovf;
    end
  end

  a_matched_bound: assert property (@(posedge clk) disable iff (rst)
    size != '0 |-> matched < size)
    else $error("matched length reached pattern length");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    size != '0 |-> bpl < size)
    else $error("build prefix reached pattern length");

endmodule

[design/kmp_stream_matcher_unit.sv]
// Streaming Knuth-Morris-Pratt matcher. Each item on "items" carries an
// opcode: clear pattern, append pattern byte, restart text, text byte or end
// of text. Pattern bytes go into an on-chip store of MAX_PATTERN bytes and
// the failure table is built as each byte arrives; extra bytes are dropped
// and flagged. Every completed match (overlaps included) returns one item on
// "results" with its start position; end of text returns the saturating
// match count, an invalid flag when the pattern is empty or longer than the
// text, and the overflow flag. Clear, restart, unused opcodes, an append
// that overflows, an append to an empty pattern and a text byte with an
// empty pattern are handled in the idle state. Any other append or text
// byte steps through the failure links; each step is one read of the
// registered pattern and failure memories followed by a compare. A text
// byte that completes a match then reads the last failure entry and loads
// the result; end of text goes straight to the result load. Failure links
// amortize to at most two steps per byte. The block takes the next item
// while the result register still holds an untaken result, and stalls only
// when a new result must be loaded over it.
module kmp_stream_matcher_unit #(
  parameter int MAX_PATTERN    = 64,
  parameter int POSITION_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  kmp_in_if.sink      items,
  kmp_out_if.source   results
);

  kmp_pkg::cmd_t  cmd;
  kmp_pkg::stat_t stat;

  // Sequence each item: decode, walk the failure links, emit
  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_opcode (items.opcode),
    .in_ready  (items.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold pattern, failure table, counters and the result register
  kmp_dp #(
    .MAX_PATTERN    (MAX_PATTERN),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .byte_value (items.byte_value),
    .results    (results)
  );

endmodule

[test/kmp_stream_matcher_unit_test.sv]
`timescale 1ns / 1ps

module kmp_stream_matcher_unit_test;

  localparam int PATTERN_CAP  = 64;
  localparam int POS_W        = 32;
  localparam int LEN_W        = $clog2(PATTERN_CAP + 1);
  localparam int ITEM_TARGET  = 1200;
  localparam int MAX_GAP      = 17;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 400;
  localparam int REPORT_LIMIT = 10;

  typedef logic [kmp_pkg::OPCODE_W-1:0] opcode_t;
  typedef logic [kmp_pkg::BYTE_W-1:0]   byte_t;

  // One result item as the block returns it.
  typedef struct packed {
    logic                         kind;
    logic [kmp_pkg::RESULT_W-1:0] position;
    logic [kmp_pkg::RESULT_W-1:0] total;
    logic                         invalid;
    logic                         overflow;
  } match_report_t;

  logic clk;
  logic rst;

  kmp_in_if  items();
  kmp_out_if results();

  kmp_stream_matcher_unit #(
    .MAX_PATTERN    (PATTERN_CAP),
    .POSITION_WIDTH (POS_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  // Matcher state as the testbench sees it: pattern, failure links, the
  // online build position, and the text side (match length, position, count).
  byte_t                        pat_mem  [PATTERN_CAP];
  logic [LEN_W-1:0]             fail_mem [PATTERN_CAP];
  logic [LEN_W-1:0]             pat_len;
  logic [LEN_W-1:0]             build_k;
  logic [LEN_W-1:0]             match_len;
  logic                         ovf_seen;
  logic [POS_W-1:0]             text_pos;
  logic [kmp_pkg::RESULT_W-1:0] match_count;

  // Results the block owes us, oldest first.
  match_report_t pending_reports[$];

  // Knobs shared between the test tasks, the input task and the output process.
  bit idle_in;
  bit idle_out;
  int hold_off_cycles;

  int items_accepted;
  int matches_seen;
  int summaries_seen;
  int invalid_seen;
  int fail_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or the handshake deadlocks.
  initial begin
    #2_000_000;
    $display("kmp_stream_matcher_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_matcher_state();
    for (int i = 0; i < PATTERN_CAP; i++) begin
      pat_mem[i]  = '0;
      fail_mem[i] = '0;
    end
    pat_len     = '0;
    build_k     = '0;
    match_len   = '0;
    ovf_seen    = 1'b0;
    text_pos    = '0;
    match_count = '0;
  endtask

  // Grow the pattern by one byte and extend the failure table online: walk
  // the failure links from the current border until the byte extends it.
  task automatic grow_pattern(byte_t b);
    logic [LEN_W-1:0] k;
    k = build_k;
    if (pat_len >= PATTERN_CAP) begin
      ovf_seen = 1'b1;
      return;
    end
    pat_mem[pat_len] = b;
    if (pat_len == 0) begin
      fail_mem[0] = '0;
      k = '0;
    end else begin
      while (k != 0 && pat_mem[k] != b)
        k = fail_mem[k - 1];
      if (pat_mem[k] == b)
        k++;
      fail_mem[pat_len] = k;
    end
    build_k = k;
    pat_len++;
  endtask

  // Advance the matcher by one text byte; queue a match report when the
  // whole pattern lines up, then fall back on the last link so overlaps count.
  task automatic scan_text_byte(byte_t c);
    logic [POS_W-1:0] idx;
    logic [LEN_W-1:0] j;
    logic [POS_W:0]   end_pos;
    match_report_t    r;
    idx = text_pos;
    if (text_pos != '1)
      text_pos++;
    if (pat_len == 0)
      return;
    j = (match_len >= pat_len) ? '0 : match_len;
    while (j != 0 && pat_mem[j] != c)
      j = fail_mem[j - 1];
    if (pat_mem[j] == c)
      j++;
    if (j == pat_len) begin
      end_pos    = {1'b0, idx} + 1'b1;
      r          = '0;
      r.kind     = kmp_pkg::RK_MATCH;
      r.position = (end_pos >= pat_len) ?
                   kmp_pkg::RESULT_W'(end_pos - pat_len) : '0;
      r.overflow = ovf_seen;
      if (match_count != '1)
        match_count++;
      pending_reports.push_back(r);
      j = fail_mem[pat_len - 1];
    end
    match_len = j;
  endtask

  task automatic predict_matcher(opcode_t op, byte_t b);
    match_report_t r;
    logic          bad;
    items_accepted++;
    case (op)
      kmp_pkg::OP_CLEAR: begin
        pat_len   = '0;
        build_k   = '0;
        ovf_seen  = 1'b0;
        match_len = '0;
      end
      kmp_pkg::OP_APPEND: begin
        grow_pattern(b);
      end
      kmp_pkg::OP_RESTART: begin
        text_pos    = '0;
        match_len   = '0;
        match_count = '0;
      end
      kmp_pkg::OP_TEXT: begin
        scan_text_byte(b);
      end
      kmp_pkg::OP_END: begin
        // Empty pattern, or pattern longer than the text seen, is invalid.
        bad        = (pat_len == 0) || (POS_W'(pat_len) > text_pos);
        r          = '0;
        r.kind     = kmp_pkg::RK_SUMMARY;
        r.total    = bad ? '0 : match_count;
        r.invalid  = bad;
        r.overflow = ovf_seen;
        pending_reports.push_back(r);
      end
      default: begin
        // Spare opcodes do nothing.
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one item per call, with an optional random gap in front.
  // Valid stays high after acceptance so back-to-back items need no bubble.
  // ---------------------------------------------------------------------------

  task automatic send_item(opcode_t op, byte_t b);
    int gap;
    gap = idle_in ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items.valid      <= 1'b1;
    items.opcode     <= op;
    items.byte_value <= b;
    @(posedge clk);
    while (!items.ready)
      @(posedge clk);
    predict_matcher(op, b);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_idle();
    @(negedge clk);
    items.valid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: a random stall before each result, plus a long hold-off
  // whenever a test asks for one.
  // ---------------------------------------------------------------------------

  initial begin : drain_results
    int gap;
    results.ready = 1'b0;
    @(negedge clk);
    while (rst)
      @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        results.ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      gap = idle_out ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        results.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      results.ready <= 1'b1;
      @(posedge clk);
      while (!results.valid)
        @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare every accepted result against the oldest owed one.
  always @(posedge clk) begin : check_results
    match_report_t got;
    match_report_t want;
    if (!rst && results.valid && results.ready) begin
      got.kind     = results.result_kind;
      got.position = results.match_position;
      got.total    = results.match_total;
      got.invalid  = results.invalid_lengths;
      got.overflow = results.pattern_overflow;
      if (got.kind == kmp_pkg::RK_MATCH)
        matches_seen++;
      else
        summaries_seen++;
      if (got.kind == kmp_pkg::RK_SUMMARY && got.invalid)
        invalid_seen++;
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected result kind=%0d pos=%0d total=%0d inv=%0d ovf=%0d",
                   $realtime, got.kind, got.position, got.total, got.invalid,
                   got.overflow);
      end else begin
        want = pending_reports.pop_front();
        if (got.kind !== want.kind || got.position !== want.position ||
            got.total !== want.total || got.invalid !== want.invalid ||
            got.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"%0t: mismatch exp kind=%0d pos=%0d total=%0d inv=%0d ovf=%0d",
                      " | got kind=%0d pos=%0d total=%0d inv=%0d ovf=%0d"},
                     $realtime, want.kind, want.position, want.total, want.invalid,
                     want.overflow, got.kind, got.position, got.total, got.invalid,
                     got.overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked cases: empty pattern, spare opcodes, extreme byte values,
  // growth mid-text, overlaps, clear keeping the position, short text.
  task automatic test_directed();
    idle_in  = 1'b0;
    idle_out = 1'b0;
    send_item(kmp_pkg::OP_END, 8'h00);       // no pattern, no text: invalid
    send_item(kmp_pkg::OP_TEXT, 8'h00);      // no pattern: only the position moves
    for (int c = int'(kmp_pkg::OP_END) + 1; c < 2 ** kmp_pkg::OPCODE_W; c++)
      send_item(opcode_t'(c), 8'hFF);
    send_item(kmp_pkg::OP_APPEND, 8'h00);
    send_item(kmp_pkg::OP_APPEND, 8'hFF);
    send_item(kmp_pkg::OP_RESTART, 8'h00);
    send_item(kmp_pkg::OP_TEXT, 8'h00);
    send_item(kmp_pkg::OP_TEXT, 8'hFF);      // match at 0
    send_item(kmp_pkg::OP_TEXT, 8'h00);
    send_item(kmp_pkg::OP_TEXT, 8'hFF);      // match at 2
    send_item(kmp_pkg::OP_TEXT, 8'hFF);
    send_item(kmp_pkg::OP_APPEND, 8'h00);    // grow the pattern in the middle of text
    send_item(kmp_pkg::OP_TEXT, 8'h00);
    send_item(kmp_pkg::OP_TEXT, 8'hFF);
    send_item(kmp_pkg::OP_TEXT, 8'h00);      // match at 5
    send_item(kmp_pkg::OP_END, 8'h00);
    send_item(kmp_pkg::OP_CLEAR, 8'hFF);     // position and count survive a clear
    send_item(kmp_pkg::OP_APPEND, 8'h55);
    send_item(kmp_pkg::OP_APPEND, 8'h55);
    repeat (3) send_item(kmp_pkg::OP_TEXT, 8'h55);  // overlapping matches
    send_item(kmp_pkg::OP_END, 8'hFF);
    send_item(kmp_pkg::OP_RESTART, 8'hFF);
    send_item(kmp_pkg::OP_TEXT, 8'h55);
    send_item(kmp_pkg::OP_END, 8'h00);       // pattern longer than text: invalid
    wait_idle();
  endtask

  // Fill the pattern store to capacity and beyond, match against it, then
  // check that a clear drops the overflow flag.
  task automatic test_capacity();
    idle_in  = ($urandom_range(0, 1) != 0);
    idle_out = ($urandom_range(0, 1) != 0);
    send_item(kmp_pkg::OP_CLEAR, 8'h00);
    repeat (PATTERN_CAP + 2) send_item(kmp_pkg::OP_APPEND, 8'hA5);
    send_item(kmp_pkg::OP_RESTART, 8'h00);
    repeat (PATTERN_CAP + 2) send_item(kmp_pkg::OP_TEXT, 8'hA5);
    send_item(kmp_pkg::OP_END, 8'h00);
    send_item(kmp_pkg::OP_CLEAR, 8'h00);
    send_item(kmp_pkg::OP_END, 8'h00);
    wait_idle();
  endtask

  // Hold off the output for a long stretch while every text byte matches,
  // so the result register stays full and the block stalls its input.
  task automatic test_backpressure();
    idle_in  = 1'b0;
    idle_out = 1'b0;
    send_item(kmp_pkg::OP_CLEAR, 8'h00);
    send_item(kmp_pkg::OP_APPEND, 8'h3C);
    send_item(kmp_pkg::OP_RESTART, 8'h00);
    hold_off_cycles = LONG_HOLD;
    repeat (40) send_item(kmp_pkg::OP_TEXT, 8'h3C);
    send_item(kmp_pkg::OP_END, 8'h00);
    wait_idle();
  endtask

  // Mostly well-formed sessions over a tiny alphabet so matches are common,
  // mixed with noise and scrambled command sequences. Run until the whole
  // test sequence has sent about the target number of items.
  task automatic test_random_sessions();
    byte_t sym [3];
    int    n_sym;
    int    pat_n;
    int    text_n;
    while (items_accepted < ITEM_TARGET) begin
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      for (int s = 0; s < 3; s++)
        sym[s] = byte_t'($urandom);
      n_sym = $urandom_range(1, 3);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 8))
            send_item(opcode_t'($urandom_range(0, 2 ** kmp_pkg::OPCODE_W - 1)),
                      byte_t'($urandom));
        end
        1: begin
          repeat ($urandom_range(3, 12))
            send_item(opcode_t'($urandom_range(kmp_pkg::OP_CLEAR, kmp_pkg::OP_END)),
                      sym[$urandom_range(0, n_sym - 1)]);
        end
        default: begin
          if ($urandom_range(0, 7) != 0)
            send_item(kmp_pkg::OP_CLEAR, byte_t'($urandom));
          // Mostly short patterns; now and then one near or past capacity.
          pat_n = ($urandom_range(0, 19) == 0) ?
                  $urandom_range(PATTERN_CAP - 4, PATTERN_CAP + 4) : $urandom_range(0, 5);
          repeat (pat_n)
            send_item(kmp_pkg::OP_APPEND, sym[$urandom_range(0, n_sym - 1)]);
          if ($urandom_range(0, 9) != 0)
            send_item(kmp_pkg::OP_RESTART, byte_t'($urandom));
          text_n = $urandom_range(0, 28);
          for (int t = 0; t < text_n; t++) begin
            if ($urandom_range(0, 39) == 0)
              send_item(kmp_pkg::OP_APPEND, sym[$urandom_range(0, n_sym - 1)]);
            if ($urandom_range(0, 15) == 0)
              send_item(kmp_pkg::OP_TEXT, byte_t'($urandom));
            else
              send_item(kmp_pkg::OP_TEXT, sym[$urandom_range(0, n_sym - 1)]);
          end
          send_item(kmp_pkg::OP_END, byte_t'($urandom));
        end
      endcase
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, report.
  // ---------------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    items.valid      = 1'b0;
    items.opcode     = kmp_pkg::OP_CLEAR;
    items.byte_value = '0;
    idle_in          = 1'b0;
    idle_out         = 1'b0;
    hold_off_cycles  = 0;
    items_accepted   = 0;
    matches_seen     = 0;
    summaries_seen   = 0;
    invalid_seen     = 0;
    fail_count       = 0;
    clear_matcher_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_capacity();
    test_backpressure();
    test_random_sessions();

    // Let any stray result show up before the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items: %0d matches, %0d end-of-text summaries (%0d invalid)",
             items_accepted, matches_seen, summaries_seen, invalid_seen);
    $display("patterns up to capacity with overflow, overlapping matches, long output stall");
    if (fail_count == 0)
      $display("kmp_stream_matcher_unit verification clean");
    else
      $display("kmp_stream_matcher_unit verification failed");
    $finish;
  end

endmodule
